// ===== src/wmt_pkg.sv =====
// Shared types, constants and helpers of the waypoint mileage tracker.
// No dependencies; the top level, the distance unit and the testbench import this package.
`timescale 1ns / 1ps

package wmt_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int MIL_W = 32;  // encoder mileage
  localparam int POS_W = 24;  // one position coordinate
  localparam int SQ_W  = 50;  // squared distance
  localparam int THR_W = 13;  // reach threshold
  localparam int ENT_W = MIL_W + 2 * POS_W;  // one table entry

  localparam logic [THR_W-1:0] THR_RESET = 13'd300;
  localparam logic [THR_W-1:0] THR_MIN   = 13'd50;
  localparam logic [THR_W-1:0] THR_MAX   = 13'd5000;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_LOAD   = 3'd2,
    OP_START  = 3'd3,
    OP_STOP   = 3'd4,
    OP_TICK   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READY = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_LOAD, S_PREV, S_READ, S_DATA, S_MEAS, S_EVAL, S_EMIT
  } state_t;

  // Request to the squared-distance unit.
  typedef struct packed {
    logic                    go;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] wx;
    logic signed [POS_W-1:0] wy;
  } dist_req_t;

  // Answer of the squared-distance unit; done pulses for one cycle.
  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] sq;
  } dist_res_t;

  function automatic logic [THR_W-1:0] clamp_thr(input logic [THR_W-1:0] v);
    logic [THR_W-1:0] r;
    if (v < THR_MIN) r = THR_MIN;
    else if (v > THR_MAX) r = THR_MAX;
    else r = v;
    return r;
  endfunction

endpackage

// ===== src/waypoint_mileage_tracker_unit.sv =====
// Top level of the waypoint mileage tracker: stream ports, control sequencer,
// waypoint table. Depends on wmt_pkg, wmt_ram and wmt_dist.
`timescale 1ns / 1ps

// Load of a non-empty table: S_EXEC, S_LOAD, S_EMIT. Tick in run mode with a target left:
// S_EXEC, S_PREV if the target is not entry 0, then per waypoint examined S_READ (table
// read), S_DATA, S_MEAS (squared distance on the shared multiplier), S_EVAL (segment
// test), then S_EMIT. Other items: S_EXEC, S_EMIT. One item at a time; the next item is
// accepted once the sequencer is idle again, even while the last result still waits.
// Reset (rst_n low, synchronous): mode idle, empty table, threshold 300 mm; no table reset.
module waypoint_mileage_tracker_unit #(
  parameter int MAX_POINTS = wmt_pkg::MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input items.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [2:0]                in_tuser,   // op
  input  logic [79:0]               in_tdata,   // encoder mileage, x position, y position
  // Result items.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // play_state, target_index, point_total, dist_sq_mm2, dist_valid, route_done
  output logic [79:0]               out_tdata,
  // Configuration: reach_threshold_mm.
  input  logic                      cfg_we,
  input  logic [wmt_pkg::THR_W-1:0] cfg_wdata
);
  import wmt_pkg::*;

  localparam int PTR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  state_t st_r, st_nxt;

  // Latched input item.
  op_t                     op_r;
  logic signed [MIL_W-1:0] enc_r;
  logic signed [POS_W-1:0] px_r, py_r;

  // Tracker state.
  mode_t             mode_r, mode_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [MIL_W-1:0]  base_r, base_nxt, start_r, start_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic              ok_r, ok_nxt;
  logic              done_r, done_nxt;
  logic [THR_W-1:0]  thr_r;
  logic [2*THR_W-1:0] thr_sq_r;

  // Per-tick working registers.
  logic signed [MIL_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, tgt_r, tgt_nxt;
  logic signed [MIL_W-1:0] delta_r, delta_nxt, prog_r, prog_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [79:0] out_data_r, out_data_nxt;

  // Table and distance unit.
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic [MIL_W-1:0] rd_mil;
  logic signed [POS_W-1:0] rd_x, rd_y;
  dist_req_t dreq;
  dist_res_t dres;

  logic in_acc, out_free;
  logic cnt_full, cnt_zero, ptr_past, last_pt;
  logic seg_hit, near, hit;
  logic [MIL_W:0] mag;
  logic val;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign rd_mil = ram_rdata[MIL_W-1:0];
  assign rd_x   = ram_rdata[MIL_W +: POS_W];
  assign rd_y   = ram_rdata[MIL_W+POS_W +: POS_W];

  assign cnt_full = (cnt_r == CNT_W'(MAX_POINTS));
  assign cnt_zero = (cnt_r == '0);
  assign ptr_past = (CNT_W'(ptr_r) >= cnt_r);
  assign last_pt  = ((CNT_W'(ptr_r) + CNT_W'(1)) >= cnt_r);

  // Segment test on the registered offsets. The nearness fallback uses the
  // distance just measured, so its valid flag is always set here.
  always_comb begin
    if (delta_r > 0) seg_hit = (prog_r >= delta_r);
    else if (delta_r < 0) seg_hit = (prog_r <= delta_r);
    else seg_hit = 1'b1;
    mag  = delta_r[MIL_W-1] ? ((MIL_W+1)'(0) - {delta_r[MIL_W-1], delta_r})
                            : {1'b0, delta_r};
    near = (mag <= (MIL_W+1)'(thr_r[THR_W-1:1])) && ok_r
           && (sq_r <= SQ_W'(thr_sq_r));
    hit  = seg_hit || near;
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_acc) st_nxt = S_EXEC;
      S_EXEC: begin
        st_nxt = S_EMIT;
        if (op_r == OP_LOAD && !cnt_zero) st_nxt = S_LOAD;
        if (op_r == OP_TICK && mode_r == MODE_RUN && !cnt_zero && !ptr_past) begin
          st_nxt = (ptr_r != '0) ? S_PREV : S_READ;
        end
      end
      S_LOAD: st_nxt = S_EMIT;
      S_PREV: st_nxt = S_READ;
      S_READ: st_nxt = S_DATA;
      S_DATA: st_nxt = S_MEAS;
      S_MEAS: if (dres.done) st_nxt = S_EVAL;
      S_EVAL: st_nxt = (hit && !last_pt) ? S_READ : S_EMIT;
      S_EMIT: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Table and distance unit control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[PTR_W-1:0];
    ram_wdata = {py_r, px_r, enc_r};
    ram_re    = 1'b0;
    ram_raddr = ptr_r;
    dreq.go   = (st_r == S_DATA);
    dreq.cx   = px_r;
    dreq.cy   = py_r;
    dreq.wx   = rd_x;
    dreq.wy   = rd_y;
    unique case (st_r)
      S_EXEC: begin
        if (op_r == OP_APPEND && !cnt_full) ram_we = 1'b1;
        if (op_r == OP_LOAD) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
        if (op_r == OP_TICK) begin
          ram_re    = 1'b1;
          ram_raddr = PTR_W'(ptr_r - PTR_W'(1));
        end
      end
      S_READ: ram_re = 1'b1;
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    base_nxt      = base_r;
    start_nxt     = start_r;
    sq_nxt        = sq_r;
    ok_nxt        = ok_r;
    done_nxt      = done_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    tgt_nxt       = tgt_r;
    delta_nxt     = tgt_r - prev_r;
    prog_nxt      = cur_r - prev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    val           = (mode_r == MODE_RUN) && ok_r;
    case (st_r)
      S_EXEC: begin
        done_nxt = 1'b0;
        unique case (op_r)
          OP_CLEAR:  cnt_nxt = '0;
          OP_APPEND: if (!cnt_full) cnt_nxt = cnt_r + CNT_W'(1);
          OP_LOAD:   if (cnt_zero) mode_nxt = MODE_IDLE;
          OP_START: begin
            if (mode_r == MODE_READY) begin
              ptr_nxt   = '0;
              ok_nxt    = 1'b0;
              sq_nxt    = '0;
              start_nxt = enc_r;
              mode_nxt  = MODE_RUN;
            end
          end
          OP_STOP: begin
            mode_nxt = MODE_IDLE;
            ok_nxt   = 1'b0;
            sq_nxt   = '0;
          end
          OP_TICK: begin
            if (mode_r == MODE_RUN) begin
              if (cnt_zero || ptr_past) begin
                mode_nxt = MODE_IDLE;
                ok_nxt   = 1'b0;
                sq_nxt   = '0;
              end else begin
                cur_nxt  = enc_r - start_r;
                prev_nxt = '0;
              end
            end
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        base_nxt = rd_mil;
        ptr_nxt  = '0;
        ok_nxt   = 1'b0;
        sq_nxt   = '0;
        mode_nxt = MODE_READY;
      end
      S_PREV: prev_nxt = rd_mil - base_r;
      S_DATA: tgt_nxt = rd_mil - base_r;
      S_MEAS: begin
        if (dres.done) begin
          sq_nxt = dres.sq;
          ok_nxt = 1'b1;
        end
      end
      S_EVAL: begin
        if (hit) begin
          if (last_pt) begin
            mode_nxt = MODE_IDLE;
            ok_nxt   = 1'b0;
            sq_nxt   = '0;
            done_nxt = 1'b1;
          end else begin
            ptr_nxt  = ptr_r + PTR_W'(1);
            prev_nxt = tgt_r;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, done_r, val, (val ? sq_r : {SQ_W{1'b0}}),
                           11'(cnt_r), 10'(ptr_r), mode_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      mode_r      <= MODE_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      base_r      <= '0;
      start_r     <= '0;
      sq_r        <= '0;
      ok_r        <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      thr_sq_r    <= 26'd90000;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      base_r      <= base_nxt;
      start_r     <= start_nxt;
      sq_r        <= sq_nxt;
      ok_r        <= ok_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) thr_r <= clamp_thr(cfg_wdata);
      // The square is registered from the threshold and follows it in the next cycle.
      thr_sq_r    <= (2*THR_W)'(thr_r) * (2*THR_W)'(thr_r);
    end
    if (in_acc) begin
      op_r  <= op_t'(in_tuser);
      enc_r <= in_tdata[MIL_W-1:0];
      px_r  <= in_tdata[MIL_W +: POS_W];
      py_r  <= in_tdata[MIL_W+POS_W +: POS_W];
    end
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    tgt_r      <= tgt_nxt;
    delta_r    <= delta_nxt;
    prog_r     <= prog_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  wmt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wmt_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .res   (dres)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[74] |-> out_tdata[1:0] == MODE_IDLE)
    else $error("route done reported while not idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[73] |-> out_tdata[1:0] == MODE_RUN)
    else $error("distance valid while not running");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table size");
  assert property (@(posedge clk) disable iff (!rst_n)
    dres.done |-> st_r == S_MEAS)
    else $error("distance result outside measurement");

endmodule

// ===== src/wmt_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module wmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/wmt_dist.sv =====
// Squared distance unit: one shared 25x25 multiplier; a new request is taken only at step 0, after the last result.
// Depends on wmt_pkg.
`timescale 1ns / 1ps

module wmt_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  wmt_pkg::dist_req_t req,
  output wmt_pkg::dist_res_t res
);
  import wmt_pkg::*;

  logic [1:0]               step_r, step_nxt;
  logic                     done_r, done_nxt;
  logic signed [POS_W:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0]          prod_r, prod_nxt, acc_r, acc_nxt, sq_r, sq_nxt;
  logic signed [POS_W:0]    m_op;
  logic signed [2*POS_W+1:0] m_full;

  // The operand alternates between dx and dy.
  assign m_op   = (step_r == 2'd1) ? dx_r : dy_r;
  assign m_full = m_op * m_op;

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    sq_nxt   = sq_r;
    case (step_r)
      2'd0: begin
        if (req.go) begin
          dx_nxt   = {req.cx[POS_W-1], req.cx} - {req.wx[POS_W-1], req.wx};
          dy_nxt   = {req.cy[POS_W-1], req.cy} - {req.wy[POS_W-1], req.wy};
          step_nxt = 2'd1;
        end
      end
      2'd1: begin
        prod_nxt = m_full[SQ_W-1:0];
        step_nxt = 2'd2;
      end
      2'd2: begin
        acc_nxt  = prod_r;
        prod_nxt = m_full[SQ_W-1:0];
        step_nxt = 2'd3;
      end
      default: begin
        sq_nxt   = acc_r + prod_r;
        done_nxt = 1'b1;
        step_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
  end

  assign res.done = done_r;
  assign res.sq   = sq_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> step_r == 2'd0)
    else $error("distance result out of step");
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == 2'd3) |=> done_r)
    else $error("distance result missing");
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == 2'd1) |=> (step_r == 2'd2))
    else $error("distance sequence broken");

endmodule

// ===== verif/waypoint_mileage_tracker_unit_tb.sv =====
// Self-checking testbench for waypoint_mileage_tracker_unit: builds routes, replays them
// with ticks, and checks every result against an in-bench route predictor.
// Depends on wmt_pkg and the RTL of the tracker.
`timescale 1ns / 1ps

module waypoint_mileage_tracker_unit_tb;
  import wmt_pkg::*;

  localparam int NPTS = 1024;
  // Codes with no operation behind them; the block only reports its status.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // One expected status item, declared from bit 74 of out_tdata down.
  typedef struct packed {
    logic        route_done;
    logic        dist_valid;
    logic [49:0] dist_sq;
    logic [10:0] point_total;
    logic [9:0]  target_index;
    logic [1:0]  play_state;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;

  // Route model: table, play mode, target and the last measured distance.
  logic signed [31:0] way_mil [NPTS];
  logic signed [23:0] way_x [NPTS];
  logic signed [23:0] way_y [NPTS];
  int unsigned        way_count;
  mode_t              play_mode;
  int unsigned        target;
  logic signed [31:0] base_mil;
  logic signed [31:0] start_mil;
  logic [63:0]        dist_sq;
  logic               dist_ok;
  int unsigned        reach_mm;

  status_t status_q[$];
  int      fail_count = 0;
  bit      idling_on = 1'b1;
  int      hold_request = 0;

  waypoint_mileage_tracker_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Squared distance from the current position to table entry idx.
  function automatic void measure_to(int unsigned idx, logic signed [23:0] cx,
                                     logic signed [23:0] cy);
    longint dx, dy;
    dx = longint'(cx) - longint'(way_x[idx]);
    dy = longint'(cy) - longint'(way_y[idx]);
    dist_sq = dx * dx + dy * dy;
    dist_ok = 1'b1;
  endfunction

  function automatic void halt_route();
    play_mode = MODE_IDLE;
    dist_ok = 1'b0;
    dist_sq = '0;
  endfunction

  // A tick: measure, then walk the target over every reached segment.
  // Returns 1 when the final waypoint was reached.
  function automatic logic advance_route(logic signed [31:0] enc, logic signed [23:0] cx,
                                         logic signed [23:0] cy);
    logic signed [31:0] cur, prev, tgt, delta, progress;
    longint mag;
    longint thr_sq;
    logic hit;
    thr_sq = longint'(reach_mm) * longint'(reach_mm);
    if (play_mode != MODE_RUN) return 1'b0;
    if (way_count == 0 || target >= way_count) begin
      halt_route();
      return 1'b0;
    end
    measure_to(target, cx, cy);
    cur = enc - start_mil;
    forever begin
      prev = (target > 0) ? way_mil[target-1] - base_mil : 32'sd0;
      tgt = way_mil[target] - base_mil;
      delta = tgt - prev;
      progress = cur - prev;
      mag = (delta < 0) ? -longint'(delta) : longint'(delta);
      if (delta > 0) hit = (progress >= delta);
      else if (delta < 0) hit = (progress <= delta);
      else hit = 1'b1;
      // Short segment: being near the waypoint counts as reaching it.
      if (!hit && mag <= longint'(reach_mm / 2) && dist_ok && longint'(dist_sq) <= thr_sq)
        hit = 1'b1;
      if (!hit) return 1'b0;
      if (target + 1 >= way_count) begin
        halt_route();
        return 1'b1;
      end
      target++;
      measure_to(target, cx, cy);
    end
  endfunction

  // Applies one accepted item to the route model and queues the status it yields.
  function automatic void predict_status(logic [2:0] op, logic signed [31:0] enc,
                                         logic signed [23:0] px, logic signed [23:0] py);
    status_t s;
    logic done;
    done = 1'b0;
    case (op)
      OP_CLEAR: way_count = 0;
      OP_APPEND: begin
        if (way_count < NPTS) begin
          way_mil[way_count] = enc;
          way_x[way_count] = px;
          way_y[way_count] = py;
          way_count++;
        end
      end
      OP_LOAD: begin
        if (way_count == 0) begin
          play_mode = MODE_IDLE;
        end else begin
          base_mil = way_mil[0];
          target = 0;
          dist_ok = 1'b0;
          dist_sq = '0;
          play_mode = MODE_READY;
        end
      end
      OP_START: begin
        if (play_mode == MODE_READY) begin
          target = 0;
          dist_ok = 1'b0;
          dist_sq = '0;
          start_mil = enc;
          play_mode = MODE_RUN;
        end
      end
      OP_STOP: halt_route();
      OP_TICK: done = advance_route(enc, px, py);
      default: ;
    endcase
    s.play_state = play_mode;
    s.target_index = target[9:0];
    s.point_total = way_count[10:0];
    s.dist_valid = (play_mode == MODE_RUN) && dist_ok;
    s.dist_sq = s.dist_valid ? dist_sq[49:0] : '0;
    s.route_done = done;
    status_q.push_back(s);
  endfunction

  // Sends one item; the sender may idle first, and valid stays up until accepted.
  task automatic send_item(logic [2:0] op, logic signed [31:0] enc = 0,
                           logic signed [23:0] px = 0, logic signed [23:0] py = 0);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {py, px, enc};
    do @(posedge clk); while (!in_tready);
    predict_status(op, enc, px, py);
  endtask

  // Sender pauses until every expected status has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the reach threshold while the block is idle; the block clamps it.
  task automatic write_threshold(logic [THR_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    reach_mm = (value < THR_MIN) ? THR_MIN : (value > THR_MAX) ? THR_MAX : value;
  endtask

  // Receiver: a requested long hold-off, random stall bursts, or ready.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_tready = 1'b0;
        hold_request--;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        stall = $urandom_range(0, 16);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Checker: every accepted status against the oldest expectation.
  always @(posedge clk) begin
    status_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[74:0];
      if (status_q.size() == 0) begin
        $error("status item with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        exp_s = status_q.pop_front();
        if (got.play_state !== exp_s.play_state) begin
          $error("play_state expected %0d got %0d", exp_s.play_state, got.play_state);
          fail_count++;
        end
        if (got.target_index !== exp_s.target_index) begin
          $error("target_index expected %0d got %0d", exp_s.target_index, got.target_index);
          fail_count++;
        end
        if (got.point_total !== exp_s.point_total) begin
          $error("point_total expected %0d got %0d", exp_s.point_total, got.point_total);
          fail_count++;
        end
        if (got.dist_sq !== exp_s.dist_sq) begin
          $error("dist_sq_mm2 expected %0d got %0d", exp_s.dist_sq, got.dist_sq);
          fail_count++;
        end
        if (got.dist_valid !== exp_s.dist_valid) begin
          $error("dist_valid expected %0d got %0d", exp_s.dist_valid, got.dist_valid);
          fail_count++;
        end
        if (got.route_done !== exp_s.route_done) begin
          $error("route_done expected %0d got %0d", exp_s.route_done, got.route_done);
          fail_count++;
        end
      end
    end
  end

  // Hand-picked route: zero, forward, backward and short segments, plus the
  // ignored cases (tick or start out of turn, load of an empty table, spare codes).
  task automatic test_directed_route();
    send_item(OP_TICK, 32'sd5, 24'sd1, 24'sd1);
    send_item(OP_START, 32'sd7);
    send_item(OP_LOAD);
    send_item(OP_SPARE6, 32'sh7fffffff, 24'sh7fffff, 24'sh800000);
    send_item(OP_SPARE7, 32'sh80000000, 24'sh800000, 24'sh7fffff);
    send_item(OP_APPEND, 32'sd1000, 24'sd0, 24'sd0);
    send_item(OP_APPEND, 32'sd1000, 24'sd10, 24'sd0);
    send_item(OP_APPEND, 32'sd3000, 24'sd2000, 24'sd0);
    send_item(OP_APPEND, 32'sd2000, 24'sd1000, 24'sd0);
    send_item(OP_APPEND, 32'sd2100, 24'sd1100, 24'sd0);
    send_item(OP_LOAD);
    send_item(OP_START, 32'sh7fffff00);
    send_item(OP_TICK, 32'sh7fffff00, 24'sd0, 24'sd0);
    send_item(OP_TICK, 32'sh80000700, 24'sd1500, 24'sd0);
    send_item(OP_TICK, 32'sh800008d0, 24'sd1000, 24'sd0);
    send_item(OP_TICK, 32'sh800008d0, 24'sd1100, 24'sd50);
    send_item(OP_TICK, 32'sd0, 24'sh7fffff, 24'sh800000);
    send_item(OP_LOAD);
    send_item(OP_START, 32'sd0);
    send_item(OP_CLEAR);
    send_item(OP_TICK, 32'sd0, 24'sd0, 24'sd0);
    send_item(OP_STOP);
  endtask

  // Build a long route, then walk all of it in one tick.
  task automatic test_long_walk();
    send_item(OP_CLEAR);
    for (int i = 0; i < 40; i++)
      send_item(OP_APPEND, 32'(i * 10), 24'(i), 24'(-i));
    send_item(OP_LOAD);
    send_item(OP_START, 32'sd0);
    send_item(OP_TICK, 32'sd100000, 24'sd3, 24'sd4);
  endtask

  // Random route: build, load, start, then ticks that mostly follow the path.
  task automatic run_random_route();
    int n, ticks;
    logic signed [31:0] m, enc;
    int unsigned pick;
    n = $urandom_range(1, 8);
    send_item(OP_CLEAR);
    m = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) m = $urandom;
      else if (pick == 1) m = m;
      else if (pick < 4) m = m + $signed(32'($urandom_range(0, 400))) - 200;
      else m = m + $signed(32'($urandom_range(0, 6000))) - 1500;
      if ($urandom_range(0, 7) == 0)
        send_item(OP_APPEND, m, 24'($urandom), 24'($urandom));
      else
        send_item(OP_APPEND, m, 24'($urandom_range(0, 20000)) - 24'sd10000,
                  24'($urandom_range(0, 20000)) - 24'sd10000);
    end
    send_item(OP_LOAD);
    enc = $urandom;
    send_item(OP_START, enc);
    ticks = $urandom_range(2, 10);
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(3'($urandom_range(0, 7)), $urandom, 24'($urandom), 24'($urandom));
      end else begin
        enc = enc + $signed(32'($urandom_range(0, 3000))) - 800;
        // Often stand near the current target so the nearness rule gets a chance.
        if (target < way_count && $urandom_range(0, 1) == 0)
          send_item(OP_TICK, enc, way_x[target] + 24'($urandom_range(0, 400)) - 24'sd200,
                    way_y[target] + 24'($urandom_range(0, 400)) - 24'sd200);
        else
          send_item(OP_TICK, enc, 24'($urandom), 24'($urandom));
      end
    end
  endtask

  task automatic test_random_routes();
    int sent;
    sent = 0;
    while (sent < 400) begin
      if (sent > 340) idling_on = 1'b0;
      if ($urandom_range(0, 4) == 0) begin
        send_item(3'($urandom_range(0, 7)), $urandom, 24'($urandom), 24'($urandom));
        sent++;
      end else begin
        run_random_route();
        sent += 14;
      end
      if ($urandom_range(0, 11) == 0 && idling_on) write_threshold(13'($urandom));
    end
  endtask

  // The receiver holds off while items keep coming, so the block backs up.
  task automatic test_output_backpressure();
    drain();
    hold_request = 300;
    for (int i = 0; i < 12; i++) send_item(OP_APPEND, $urandom, 24'($urandom), 24'($urandom));
    send_item(OP_LOAD);
    send_item(OP_START, 32'sd0);
    for (int i = 0; i < 6; i++) send_item(OP_TICK, $urandom, 24'($urandom), 24'($urandom));
    drain();
  endtask

  task automatic test_threshold_extremes();
    write_threshold(13'd0);
    run_random_route();
    write_threshold(13'h1fff);
    run_random_route();
    write_threshold(THR_MIN);
    run_random_route();
    write_threshold(THR_MAX);
    run_random_route();
    write_threshold(13'd5001);
    write_threshold(13'd49);
    write_threshold(THR_RESET);
  endtask

  initial begin
    for (int i = 0; i < NPTS; i++) begin
      way_mil[i] = '0;
      way_x[i] = '0;
      way_y[i] = '0;
    end
    way_count = 0;
    play_mode = MODE_IDLE;
    target = 0;
    base_mil = '0;
    start_mil = '0;
    dist_sq = '0;
    dist_ok = 1'b0;
    reach_mm = THR_RESET;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed_route();
    test_long_walk();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_routes();
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (status_q.size() != 0) $error("%0d status items never arrived", status_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
